@@ rtl/mpwc_pkg.sv @@
// Shared types and constants for the motor phase wiring check block.
`timescale 1ns / 1ps
package mpwc_pkg;

    // Op codes of an input word; any other code acts as a plain tick
    localparam logic [1:0] OP_INIT = 2'd1;
    localparam logic [1:0] OP_SKIP = 2'd2;

    // Sequencer phase codes, reported on phase_code
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_DRIVE_AB = 3'd1;
    localparam logic [2:0] PH_WAIT_ZERO = 3'd2;
    localparam logic [2:0] PH_DRIVE_AC = 3'd3;
    localparam logic [2:0] PH_FAILED   = 3'd4;
    localparam logic [2:0] PH_PASSED   = 3'd5;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 3;
    localparam int          CFG_DATA_W      = 16;
    localparam logic [2:0] CFG_CHECK_EFFORT = 3'd0;
    localparam logic [2:0] CFG_PWM_HALF     = 3'd1;
    localparam logic [2:0] CFG_MOTOR_IS_DC  = 3'd2;
    localparam logic [2:0] CFG_MIN_DRIVE    = 3'd3;
    localparam logic [2:0] CFG_ZERO_LOW     = 3'd4;
    localparam logic [2:0] CFG_ZERO_HIGH    = 3'd5;
    localparam logic [2:0] CFG_WAIT_TICKS   = 3'd6;
    localparam logic [2:0] CFG_RETRY_LIMIT  = 3'd7;

    // Configuration reset values
    localparam logic [14:0] RST_MIN_DRIVE   = 15'd750;
    localparam logic [15:0] RST_ZERO_LOW    = 16'hFF38;   // -200
    localparam logic [14:0] RST_ZERO_HIGH   = 15'd200;
    localparam logic [15:0] RST_WAIT_TICKS  = 16'd10;
    localparam logic [15:0] RST_RETRY_LIMIT = 16'd10;

    // Duty effort is in 0.01 percent steps
    localparam longint EFFORT_FULL_SCALE = 64'd10000;

    typedef struct packed {
        logic [1:0]         op;
        logic               start_request;
        logic signed [15:0] current_a;
        logic signed [15:0] current_c;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  phase_code;
        logic        seq_busy;
        logic        check_attained;
        logic        check_failed;
        logic        fault_raise;
        logic        fault_clear;
        logic        drive_a_on;
        logic        drive_b_on;
        logic        drive_c_on;
        logic [15:0] high_compare;
        logic [15:0] low_compare;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic mul_en;
        logic mul_second;   // 0: k * effort, 1: x * half period
        logic commit_step;
        logic commit_init;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_is_init;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/mpwc_ctrl.sv @@
// Controller state machine sequencing word intake, compare multiply and commit.
`timescale 1ns / 1ps
module mpwc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mpwc_pkg::t_dp_stat i_stat,
    output mpwc_pkg::t_dp_cmd  o_cmd
);
    import mpwc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_MUL1 = 5'b00100,
        S_MUL2 = 5'b01000,
        S_INIT = 5'b10000
    } t_ctrl_state;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_stat.in_is_init ? S_MUL1 : S_STEP;
                end
            end
            S_MUL1: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_second = 1'b1;
                n_state = S_INIT;
            end
            S_INIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit_init = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_STEP: begin
                if (i_stat.out_free) begin
                    o_cmd.commit_step = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/mpwc_dp.sv @@
// Datapath: config registers, sequencer state, shared compare multiplier, output word.
`timescale 1ns / 1ps
module mpwc_dp #(
    parameter int FRACTION_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mpwc_pkg::t_in_word                  i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output mpwc_pkg::t_out_word                 o_data,
    input  logic                                i_cfg_we,
    input  logic [mpwc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mpwc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  mpwc_pkg::t_dp_cmd                   i_cmd,
    output mpwc_pkg::t_dp_stat                  o_stat
);
    import mpwc_pkg::*;

    localparam int PW = FRACTION_BITS + 16;
    localparam logic [PW-1:0] ONE_Q = PW'(1) << FRACTION_BITS;
    localparam logic [FRACTION_BITS-1:0] K_Q =
        FRACTION_BITS'((64'd1 << FRACTION_BITS) / EFFORT_FULL_SCALE);

    // configuration
    logic [15:0] r_effort, r_pwm_half, r_zero_low, r_wait_ticks, r_retry_limit;
    logic [14:0] r_min_drive, r_zero_high;
    logic        r_is_dc;

    // sequencer state
    logic [2:0]  r_seq, n_seq;
    logic [15:0] r_tick, n_tick, r_retry, n_retry;
    logic        r_pend, n_pend, r_run, n_run, r_att, n_att, r_fail, n_fail;
    logic [15:0] r_cmp_high, n_cmp_high, r_cmp_low, n_cmp_low;

    t_in_word    r_in;
    t_out_word   r_out, n_out;
    logic        r_out_valid;
    logic [PW-1:0] r_prod, n_prod;

    logic [PW-1:0]            aux_clamped, frac_diff;
    logic [FRACTION_BITS-1:0] mul_a;
    logic [15:0]              mul_b;
    logic [15:0]              tick_inc, retry_inc;
    logic                     raise, clear;
    logic signed [17:0]       ia, ic, sum_ac, mn, zl, zh;
    logic                     commit;

    assign o_stat.in_is_init = (i_data.op == OP_INIT);
    assign o_stat.out_free   = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign commit  = i_cmd.commit_step || i_cmd.commit_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effort      <= '0;
            r_pwm_half    <= '0;
            r_is_dc       <= 1'b0;
            r_min_drive   <= RST_MIN_DRIVE;
            r_zero_low    <= RST_ZERO_LOW;
            r_zero_high   <= RST_ZERO_HIGH;
            r_wait_ticks  <= RST_WAIT_TICKS;
            r_retry_limit <= RST_RETRY_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHECK_EFFORT: r_effort      <= i_cfg_data;
                CFG_PWM_HALF:     r_pwm_half    <= i_cfg_data;
                CFG_MOTOR_IS_DC:  r_is_dc       <= i_cfg_data[0];
                CFG_MIN_DRIVE:    r_min_drive   <= i_cfg_data[14:0];
                CFG_ZERO_LOW:     r_zero_low    <= i_cfg_data;
                CFG_ZERO_HIGH:    r_zero_high   <= i_cfg_data[14:0];
                CFG_WAIT_TICKS:   r_wait_ticks  <= i_cfg_data;
                CFG_RETRY_LIMIT:  r_retry_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Compare pair: aux = min(k * effort, 1.0); x = (1.0 - aux) / 2; high = x * hp
    always_comb begin
        aux_clamped = (r_prod > ONE_Q) ? ONE_Q : r_prod;
        frac_diff   = ONE_Q - aux_clamped;
        mul_a       = i_cmd.mul_second ? frac_diff[FRACTION_BITS:1] : K_Q;
        mul_b       = i_cmd.mul_second ? r_pwm_half : r_effort;
        n_prod      = PW'(mul_a) * PW'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_data;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        ia     = 18'(r_in.current_a);
        ic     = 18'(r_in.current_c);
        sum_ac = ia + ic;
        mn     = $signed({3'b000, r_min_drive});
        zl     = 18'($signed(r_zero_low));
        zh     = $signed({3'b000, r_zero_high});
        tick_inc  = r_tick + 16'd1;
        retry_inc = (r_retry != 16'hFFFF) ? r_retry + 16'd1 : r_retry;

        n_seq      = r_seq;
        n_tick     = r_tick;
        n_retry    = r_retry;
        n_pend     = r_pend;
        n_run      = r_run;
        n_att      = r_att;
        n_fail     = r_fail;
        n_cmp_high = r_cmp_high;
        n_cmp_low  = r_cmp_low;
        raise      = 1'b0;
        clear      = 1'b0;

        if (i_cmd.commit_init) begin
            n_seq      = PH_IDLE;
            n_retry    = '0;
            n_cmp_high = r_prod[PW-1:FRACTION_BITS];
            n_cmp_low  = r_pwm_half - r_prod[PW-1:FRACTION_BITS];
        end else if (i_cmd.commit_step) begin
            if (r_in.start_request) begin
                n_pend = 1'b1;
                n_att  = 1'b0;
                n_fail = 1'b0;
            end
            if (r_in.op == OP_SKIP) begin
                n_run = 1'b0;
                n_seq = PH_IDLE;
            end else begin
                case (r_seq)
                    PH_IDLE: begin
                        if (n_pend) begin
                            n_pend = 1'b0;
                            n_run  = 1'b1;
                            n_seq  = PH_DRIVE_AB;
                        end
                    end
                    PH_DRIVE_AB, PH_WAIT_ZERO, PH_DRIVE_AC: begin
                        n_tick = tick_inc;
                        if (tick_inc < r_wait_ticks) begin
                            if (r_seq == PH_DRIVE_AB) begin
                                if (ia > mn && ic > zl && ic < zh) begin
                                    n_tick = '0;
                                    n_seq  = r_is_dc ? PH_PASSED : PH_WAIT_ZERO;
                                end
                            end else if (r_seq == PH_WAIT_ZERO) begin
                                if (ia < zh && ic < zh) begin
                                    n_tick = '0;
                                    n_seq  = PH_DRIVE_AC;
                                end
                            end else begin
                                if (ia > mn && sum_ac > zl && sum_ac < zh) begin
                                    n_tick = '0;
                                    n_seq  = PH_PASSED;
                                end
                            end
                        end else begin
                            n_tick = '0;
                            n_seq  = PH_FAILED;
                        end
                    end
                    PH_FAILED: begin
                        n_retry = retry_inc;
                        n_seq   = PH_IDLE;
                        if (retry_inc > r_retry_limit) begin
                            n_fail = 1'b1;
                            raise  = 1'b1;
                            n_run  = 1'b0;
                        end else begin
                            n_pend = 1'b1;
                        end
                    end
                    PH_PASSED: begin
                        n_att   = 1'b1;
                        clear   = 1'b1;
                        n_retry = '0;
                        n_run   = 1'b0;
                        n_seq   = PH_IDLE;
                    end
                    default: begin
                        n_seq = PH_IDLE;
                    end
                endcase
            end
        end

        n_out.phase_code     = n_seq;
        n_out.seq_busy       = n_run;
        n_out.check_attained = n_att;
        n_out.check_failed   = n_fail;
        n_out.fault_raise    = raise;
        n_out.fault_clear    = clear;
        n_out.drive_a_on     = (n_seq == PH_DRIVE_AB) || (n_seq == PH_DRIVE_AC);
        n_out.drive_b_on     = (n_seq == PH_DRIVE_AB);
        n_out.drive_c_on     = (n_seq == PH_DRIVE_AC);
        n_out.high_compare   = n_out.drive_a_on ? n_cmp_high : 16'd0;
        n_out.low_compare    = n_out.drive_a_on ? n_cmp_low : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= PH_IDLE;
            r_tick      <= '0;
            r_retry     <= '0;
            r_pend      <= 1'b0;
            r_run       <= 1'b0;
            r_att       <= 1'b0;
            r_fail      <= 1'b0;
            r_cmp_high  <= '0;
            r_cmp_low   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_seq      <= n_seq;
                r_tick     <= n_tick;
                r_retry    <= n_retry;
                r_pend     <= n_pend;
                r_run      <= n_run;
                r_att      <= n_att;
                r_fail     <= n_fail;
                r_cmp_high <= n_cmp_high;
                r_cmp_low  <= n_cmp_low;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/motor_phase_wiring_check.sv @@
// Top level of the motor phase wiring check sequencer.
`timescale 1ns / 1ps
// One input word per control tick advances the wiring check: drive A/B, wait for
// zero current, drive A/C (a DC motor passes after A/B), with retries and a fault
// after the retry limit. A tick or skip word is captured, then its state update is
// written to the output register; an init word is captured, then its compare pair
// is formed by one shared multiplier used twice (k * effort, then the duty fraction
// times the half period) and latched. One word is in work at a time; the next word
// is taken as soon as the previous one is written to the output register, even
// while that result still waits for the consumer. Configuration writes land
// immediately and must only be issued while no word is in work.
module motor_phase_wiring_check #(
    parameter int FRACTION_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  mpwc_pkg::t_in_word              i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output mpwc_pkg::t_out_word             o_data,
    input  logic                            i_cfg_we,
    input  logic [mpwc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mpwc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mpwc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mpwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mpwc_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule
